// ----- hdl/hfi_pkg.sv -----
// ----------------------------------------------------------------------------
// hfi_pkg
// Types and constants shared by the square-wave HFI rotor angle observer.
// ----------------------------------------------------------------------------
package hfi_pkg;

	localparam int AddrWidth = 5;
	localparam int DataWidth = 32;

	// Register indexes, taken from paddr[4:2].
	localparam logic [2:0] RegSinInject  = 3'd0;
	localparam logic [2:0] RegCosInject  = 3'd1;
	localparam logic [2:0] RegCompOffset = 3'd2;
	localparam logic [2:0] RegPropGain   = 3'd3;
	localparam logic [2:0] RegIntegGain  = 3'd4;
	localparam logic [2:0] RegAngleGain  = 3'd5;

	localparam logic signed [15:0] CosInjectReset = 16'sd32767;

	// Shared multiply-accumulate unit widths.
	localparam int MacAWidth   = 33;
	localparam int MacBWidth   = 21;
	localparam int MacAccWidth = 55;

	typedef struct packed {
		logic signed [15:0] delta_d;
		logic signed [15:0] delta_q;
		logic               inject_negative;
		logic               enable;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] speed;
		logic signed [15:0] angle;
	} result_t;

	typedef struct packed {
		logic signed [15:0] sin_inject;
		logic signed [15:0] cos_inject;
		logic signed [15:0] comp_offset;
		logic        [31:0] prop_gain;
		logic        [31:0] integ_gain;
		logic        [15:0] angle_gain;
	} cfg_t;

	typedef struct packed {
		logic                          en;
		logic                          clear;
		logic signed [MacAWidth-1:0]   a;
		logic signed [MacBWidth-1:0]   b;
	} mac_ctrl_t;

endpackage

// ----- hdl/hfi_regs.sv -----
// ----------------------------------------------------------------------------
// hfi_regs
// APB-style configuration registers: injection sine and cosine, offset, gains.
// ----------------------------------------------------------------------------
module hfi_regs import hfi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0] pwdata,
	output logic [DataWidth-1:0] prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sin_inject  <= '0;
			cfg_q.cos_inject  <= CosInjectReset;
			cfg_q.comp_offset <= '0;
			cfg_q.prop_gain   <= '0;
			cfg_q.integ_gain  <= '0;
			cfg_q.angle_gain  <= '0;
		end else if (wr) begin
			case (idx)
				RegSinInject:  cfg_q.sin_inject  <= pwdata[15:0];
				RegCosInject:  cfg_q.cos_inject  <= pwdata[15:0];
				RegCompOffset: cfg_q.comp_offset <= pwdata[15:0];
				RegPropGain:   cfg_q.prop_gain   <= pwdata;
				RegIntegGain:  cfg_q.integ_gain  <= pwdata;
				RegAngleGain:  cfg_q.angle_gain  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			RegSinInject:  prdata = {16'd0, cfg_q.sin_inject};
			RegCosInject:  prdata = {16'd0, cfg_q.cos_inject};
			RegCompOffset: prdata = {16'd0, cfg_q.comp_offset};
			RegPropGain:   prdata = cfg_q.prop_gain;
			RegIntegGain:  prdata = cfg_q.integ_gain;
			RegAngleGain:  prdata = {16'd0, cfg_q.angle_gain};
			default:       prdata = '0;
		endcase
	end

endmodule

// ----- hdl/hfi_mac.sv -----
// ----------------------------------------------------------------------------
// hfi_mac
// Shared signed multiply-accumulate unit used by every product of the loop.
// ----------------------------------------------------------------------------
module hfi_mac import hfi_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mac_ctrl_t                     ctrl,
	output logic signed [MacAccWidth-1:0] acc
);

	logic signed [MacAccWidth-1:0]           acc_q;
	logic signed [MacAWidth+MacBWidth-1:0]   prod;
	logic signed [MacAccWidth-1:0]           base;

	assign prod = ctrl.a * ctrl.b;
	assign base = ctrl.clear ? '0 : acc_q;
	assign acc  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.en) begin
			acc_q <= base + {prod[MacAWidth+MacBWidth-1], prod};
		end
	end

endmodule

// ----- hdl/hfi_core.sv -----
// ----------------------------------------------------------------------------
// hfi_core
// Sequencer: demodulation, error, PI speed update and angle step, each product
// taken in turn through the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module hfi_core import hfi_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  sample_t                       sample,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	output result_t                       result,
	output logic                          result_valid,
	input  logic                          result_ready,
	output mac_ctrl_t                     mac_ctrl,
	input  logic signed [MacAccWidth-1:0] mac_acc
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SIN, ST_COS, ST_ERR, ST_KP, ST_KI, ST_SPD, ST_ANG, ST_DONE
	} state_t;

	state_t               state_q;
	sample_t              sample_q;
	logic signed [19:0]   err_q;
	logic signed [19:0]   last_q;
	logic signed [31:0]   speed_q;
	logic signed [15:0]   angle_q;
	result_t              result_q;
	logic                 result_valid_q;

	logic signed [MacAccWidth-1:0] sum_n;
	logic signed [19:0]            err;
	logic signed [20:0]            diff;
	logic signed [40:0]            spd_sum;
	logic signed [31:0]            spd_sat;
	logic signed [15:0]            angle_new;
	logic                          out_free;

	assign sample_ready = (state_q == ST_IDLE);
	assign result       = result_q;
	assign result_valid = result_valid_q;
	assign out_free     = !result_valid_q || result_ready;

	// The demodulation sign is applied to the projected sum, then floored by 2^15.
	assign sum_n = sample_q.inject_negative ? -mac_acc : mac_acc;
	assign err   = sum_n[34:15] - {{4{cfg.comp_offset[15]}}, cfg.comp_offset};
	assign diff  = {err_q[19], err_q} - {last_q[19], last_q};

	assign spd_sum = {{9{speed_q[31]}}, speed_q} + {mac_acc[54], mac_acc[54:15]};
	always_comb begin
		if (spd_sum[40:31] == {10{spd_sum[40]}}) begin
			spd_sat = spd_sum[31:0];
		end else begin
			spd_sat = spd_sum[40] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
	end

	assign angle_new = angle_q + mac_acc[47:32];

	always_comb begin
		mac_ctrl = '0;
		case (state_q)
			ST_SIN: begin
				mac_ctrl.en    = 1'b1;
				mac_ctrl.clear = 1'b1;
				mac_ctrl.a     = {{17{cfg.sin_inject[15]}}, cfg.sin_inject};
				mac_ctrl.b     = {{5{sample_q.delta_d[15]}}, sample_q.delta_d};
			end
			ST_COS: begin
				mac_ctrl.en = 1'b1;
				mac_ctrl.a  = {{17{cfg.cos_inject[15]}}, cfg.cos_inject};
				mac_ctrl.b  = {{5{sample_q.delta_q[15]}}, sample_q.delta_q};
			end
			ST_KP: begin
				mac_ctrl.en    = 1'b1;
				mac_ctrl.clear = 1'b1;
				mac_ctrl.a     = {1'b0, cfg.prop_gain};
				mac_ctrl.b     = diff;
			end
			ST_KI: begin
				mac_ctrl.en = 1'b1;
				mac_ctrl.a  = {1'b0, cfg.integ_gain};
				mac_ctrl.b  = {err_q[19], err_q};
			end
			ST_ANG: begin
				mac_ctrl.en    = 1'b1;
				mac_ctrl.clear = 1'b1;
				mac_ctrl.a     = {speed_q[31], speed_q};
				mac_ctrl.b     = {5'd0, cfg.angle_gain};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sample_q       <= '0;
			err_q          <= '0;
			last_q         <= '0;
			speed_q        <= '0;
			angle_q        <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// In the final step the output register is either reloaded or still held.
			if (result_valid_q && result_ready && state_q != ST_DONE) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						sample_q <= sample;
						state_q  <= ST_SIN;
					end
				end
				ST_SIN: state_q <= ST_COS;
				ST_COS: state_q <= ST_ERR;
				ST_ERR: begin
					err_q   <= err;
					state_q <= ST_KP;
				end
				ST_KP: state_q <= ST_KI;
				ST_KI: state_q <= ST_SPD;
				ST_SPD: begin
					// With the loop disabled the error and speed are both cleared.
					if (sample_q.enable) begin
						speed_q <= spd_sat;
						last_q  <= err_q;
					end else begin
						speed_q <= '0;
						last_q  <= '0;
					end
					state_q <= ST_ANG;
				end
				ST_ANG: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						angle_q        <= angle_new;
						result_q.speed <= speed_q;
						result_q.angle <= angle_new;
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/hfi_square_wave_pll_observer.sv -----
// A result is registered in the last of the eight steps of the sequencer, which
// run around one shared multiply-accumulate unit; that last step waits while an
// untaken result still holds the output register. The sequencer takes no new
// item until the result is in the output register, which may still wait to be taken.
// Reset: arst_n clears the loop error, speed and angle and loads the register
// reset values at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// hfi_square_wave_pll_observer
// Square-wave HFI rotor angle observer with an incremental PI phase-locked loop.
// ----------------------------------------------------------------------------
module hfi_square_wave_pll_observer import hfi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0] pwdata,
	output logic [DataWidth-1:0] prdata,
	output logic                 pready,
	input  sample_t              sample,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	output result_t              result,
	output logic                 result_valid,
	input  logic                 result_ready
);

	cfg_t                          cfg;
	mac_ctrl_t                     mac_ctrl;
	logic signed [MacAccWidth-1:0] mac_acc;

	hfi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hfi_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.acc    (mac_acc)
	);

	hfi_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.mac_ctrl     (mac_ctrl),
		.mac_acc      (mac_acc)
	);

endmodule

// ----- hdl/hfi_checker.sv -----
// ----------------------------------------------------------------------------
// hfi_checker
// Port-level checks of the observer's handshakes and sequencing.
// ----------------------------------------------------------------------------
module hfi_checker import hfi_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input sample_t sample,
	input logic    sample_valid,
	input logic    sample_ready,
	input result_t result,
	input logic    result_valid,
	input logic    result_ready
);

	// An item that is not taken stays on the input port unchanged.
	a_sample_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_ready |=> sample_valid && $stable(sample))
		else $error("input item changed or dropped while waiting");

	// A result that is not taken stays on the port unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// The block is busy right after it takes an item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("item accepted while a previous one is in progress");

	// No result can appear in the cycle right after an item is taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !$rose(result_valid))
		else $error("result appeared too early");

	// A new result is posted only as the sequencer returns to waiting for input.
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> sample_ready)
		else $error("result posted while the sequencer is still busy");

endmodule

bind hfi_square_wave_pll_observer hfi_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample       (sample),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result       (result),
	.result_valid (result_valid),
	.result_ready (result_ready)
);

// ----- verif/hfi_square_wave_pll_observer_test.sv -----
// ----------------------------------------------------------------------------
// hfi_square_wave_pll_observer_test
// Self-checking bench for the HFI rotor angle observer. It keeps its own copy
// of the demodulator, the incremental PI loop and the angle integrator. Every
// item accepted on the sample port is tracked, and every item taken from the
// result port is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module hfi_square_wave_pll_observer_test;
	import hfi_pkg::*;

	localparam logic [2:0] RegSpareLo = 3'd6;
	localparam logic [2:0] RegSpareHi = 3'd7;
	localparam longint SpeedMax = 64'sd2147483647;
	localparam longint SpeedMin = -64'sd2147483648;
	localparam logic [15:0] FieldCorners [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [AddrWidth-1:0] paddr = '0;
	logic [DataWidth-1:0] pwdata = '0;
	logic [DataWidth-1:0] prdata;
	logic                 pready;
	sample_t              sample = '0;
	logic                 sample_valid = 1'b0;
	logic                 sample_ready;
	result_t              result;
	logic                 result_valid;
	logic                 result_ready = 1'b0;

	// Shadow copy of the registers and of the loop state.
	cfg_t        gains = '{16'sd0, CosInjectReset, 16'sd0, 32'd0, 32'd0, 16'd0};
	longint      loop_error = 0;
	longint      loop_speed = 0;
	logic [15:0] loop_angle = '0;

	sample_t pending_samples [$];
	result_t expected_results [$];
	int      sender_idle_pct = 29;
	int      receiver_stall_pct = 71;
	int      failures = 0;

	hfi_square_wave_pll_observer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

	always #5 clk = ~clk;

	function automatic result_t track_rotor(sample_t s);
		longint  dd, dq, err, inc, sum, step;
		longint  kp, ki, kang;
		result_t r;
		dd = longint'(s.delta_d);
		dq = longint'(s.delta_q);
		kp = longint'(gains.prop_gain);
		ki = longint'(gains.integ_gain);
		kang = longint'(gains.angle_gain);
		if (s.inject_negative) begin
			dd = -dd;
			dq = -dq;
		end
		err = ((dd * longint'(gains.sin_inject) + dq * longint'(gains.cos_inject)) >>> 15)
			- longint'(gains.comp_offset);
		if (s.enable) begin
			inc = kp * (err - loop_error) + ki * err;
			sum = loop_speed + (inc >>> 15);
			loop_speed = (sum > SpeedMax) ? SpeedMax : (sum < SpeedMin) ? SpeedMin : sum;
			loop_error = err;
		end else begin
			loop_speed = 0;
			loop_error = 0;
		end
		step = (loop_speed * kang) >>> 32;
		loop_angle = loop_angle + step[15:0];
		r.speed = loop_speed[31:0];
		r.angle = loop_angle;
		return r;
	endfunction

	function automatic sample_t make_sample(logic [15:0] dd, logic [15:0] dq, logic neg, logic en);
		sample_t s;
		s.delta_d = dd;
		s.delta_q = dq;
		s.inject_negative = neg;
		s.enable = en;
		return s;
	endfunction

	// Most items follow a square-wave response around a per-phase operating
	// point, with the sign alternating; the rest are unrelated noise.
	function automatic sample_t random_sample(int k, logic [15:0] base_d, logic [15:0] base_q);
		sample_t     s;
		logic [15:0] nd, nq;
		nd = 16'(int'($urandom_range(0, 255)) - 128);
		nq = 16'(int'($urandom_range(0, 255)) - 128);
		if ($urandom_range(99) < 75) begin
			s.inject_negative = k[0];
			s.delta_d = k[0] ? -base_d + nd : base_d + nd;
			s.delta_q = k[0] ? -base_q + nq : base_q + nq;
			s.enable = ($urandom_range(49) != 0);
		end else begin
			s.delta_d = ($urandom_range(3) == 0) ?
				FieldCorners[2'($urandom_range(3))] : 16'($urandom);
			s.delta_q = ($urandom_range(3) == 0) ?
				FieldCorners[2'($urandom_range(3))] : 16'($urandom);
			s.inject_negative = 1'($urandom_range(1));
			s.enable = ($urandom_range(3) != 0);
		end
		return s;
	endfunction

	function automatic cfg_t random_gains(bit gentle);
		cfg_t c;
		c.sin_inject = 16'($urandom);
		c.cos_inject = 16'($urandom);
		c.angle_gain = 16'($urandom);
		if (gentle) begin
			c.comp_offset = 16'(int'($urandom_range(0, 512)) - 256);
			c.prop_gain = $urandom_range(0, 32'h0004_0000);
			c.integ_gain = $urandom_range(0, 32'h0001_0000);
		end else begin
			c.comp_offset = 16'($urandom);
			c.prop_gain = $urandom;
			c.integ_gain = $urandom;
		end
		return c;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			RegSinInject:  gains.sin_inject = value[15:0];
			RegCosInject:  gains.cos_inject = value[15:0];
			RegCompOffset: gains.comp_offset = value[15:0];
			RegPropGain:   gains.prop_gain = value;
			RegIntegGain:  gains.integ_gain = value;
			RegAngleGain:  gains.angle_gain = value[15:0];
			default: ;
		endcase
	endtask

	// Upper data bits are filled with noise; the block must drop them.
	task automatic apply_gains(input cfg_t c);
		write_reg(RegSinInject, {16'($urandom), c.sin_inject});
		write_reg(RegCosInject, {16'($urandom), c.cos_inject});
		write_reg(RegCompOffset, {16'($urandom), c.comp_offset});
		write_reg(RegPropGain, c.prop_gain);
		write_reg(RegIntegGain, c.integ_gain);
		write_reg(RegAngleGain, {16'($urandom), c.angle_gain});
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!sample_valid || sample_ready) begin
			if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				sample <= pending_samples.pop_front();
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (sample_valid && sample_ready)
				expected_results.push_back(track_rotor(sample));
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected result: speed %0d angle %0d",
							result.speed, result.angle);
				end else begin
					want = expected_results.pop_front();
					if (result.speed !== want.speed || result.angle !== want.angle) begin
						failures++;
						if (failures <= 10)
							$display("mismatch: speed exp %0d got %0d, angle exp %0d got %0d",
								want.speed, result.speed, want.angle, result.angle);
					end
				end
			end
		end
	end

	initial begin
		cfg_t        setting;
		logic [15:0] base_d, base_q;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset register values first, then writes to unmapped slots.
		pending_samples.push_back(make_sample(16'h7FFF, 16'h8000, 1'b0, 1'b1));
		pending_samples.push_back(make_sample(16'h8000, 16'h7FFF, 1'b1, 1'b1));
		wait_idle();
		write_reg(RegSpareLo, $urandom);
		write_reg(RegSpareHi, $urandom);

		apply_gains('{16'sh5A82, 16'sh5A82, -16'sd200, 32'h0003_0000, 32'h0000_4000, 16'h8000});
		pending_samples.push_back(make_sample(16'h8000, 16'h8000, 1'b0, 1'b1));
		pending_samples.push_back(make_sample(16'h8000, 16'h8000, 1'b1, 1'b1));
		pending_samples.push_back(make_sample(16'h7FFF, 16'h7FFF, 1'b0, 1'b1));
		pending_samples.push_back(make_sample(16'h7FFF, 16'h7FFF, 1'b1, 1'b1));
		pending_samples.push_back(make_sample(16'h0000, 16'h0000, 1'b0, 1'b1));
		pending_samples.push_back(make_sample(16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
		pending_samples.push_back(make_sample(16'h8000, 16'h7FFF, 1'b0, 1'b1));
		pending_samples.push_back(make_sample(16'h1234, 16'hEDCC, 1'b1, 1'b1));
		pending_samples.push_back(make_sample(16'h7FFF, 16'h7FFF, 1'b0, 1'b0));
		pending_samples.push_back(make_sample(16'h0000, 16'h0000, 1'b0, 1'b1));
		wait_idle();

		// Full gains: drive the speed into both limits and wrap the angle.
		apply_gains('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF});
		repeat (4) pending_samples.push_back(make_sample(16'h7FFF, 16'h7FFF, 1'b0, 1'b1));
		pending_samples.push_back(make_sample(16'h7FFF, 16'h7FFF, 1'b0, 1'b0));
		repeat (3) pending_samples.push_back(make_sample(16'h8000, 16'h8000, 1'b0, 1'b1));
		pending_samples.push_back(make_sample(16'h8000, 16'h8000, 1'b1, 1'b1));
		pending_samples.push_back(make_sample(16'h8000, 16'h8000, 1'b1, 1'b0));

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			if (p < 2) begin
				sender_idle_pct = 29;
				receiver_stall_pct = 71;
			end else if (p < 4) begin
				sender_idle_pct = 71;
				receiver_stall_pct = 29;
			end else begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			case (p)
				1: setting = '{16'sh7FFF, -16'sh8000, -16'sh8000, 32'hFFFF_FFFF, 32'd1, 16'hFFFF};
				2: setting = '{-16'sh8000, -16'sh8000, 16'sh7FFF, 32'd0, 32'd0, 16'd0};
				default: setting = random_gains(p == 0 || p == 5);
			endcase
			apply_gains(setting);
			base_d = 16'($urandom);
			base_q = 16'($urandom);
			for (int k = 0; k < 75; k++)
				pending_samples.push_back(random_sample(k, base_d, base_q));
		end

		wait_idle();
		repeat (16) @(posedge clk);
		if (failures == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
